### rtl/piv_pkg.sv
// Shared types and constants of the pack index entry validator.
package piv_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SIZE_W   = 28;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] FIRST_OFFSET_RESET = 32'd1036832;
  localparam logic [SIZE_W-1:0] FILE_SIZE_RESET    = 28'd0;
  localparam logic [CODE_W-1:0] MISSING_CODE_RESET = 8'd0;
  localparam logic [CODE_W-1:0] MIXED_CODE_RESET   = 8'd2;

  localparam logic [7:0] MIN_SAMPLES   = 8'd2;
  localparam logic [7:0] MAX_SAMPLES   = 8'd121;
  localparam logic [2:0] BYTE_ROUND_UP = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_CODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIXED_CODE   = 2'd3;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_SKIPPED   = 2'd3
  } status_t;

  typedef struct packed {
    logic              first_entry;
    logic              last_entry;
    logic [7:0]        coverage_code;
    logic [7:0]        lon_samples;
    logic [7:0]        lat_samples;
    logic [7:0]        reserved_byte;
    logic [DATA_W-1:0] payload_offset;
    logic [DATA_W-1:0] payload_bytes;
    logic [DATA_W-1:0] payload_checksum;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [ENTRY_W-1:0] entry_index;
    logic [DATA_W-1:0]  running_offset_out;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] first_payload_offset;
    logic [SIZE_W-1:0] declared_file_size;
    logic [CODE_W-1:0] missing_code;
    logic [CODE_W-1:0] mixed_code;
  } cfg_t;

  // Classified entry passed from the front to the back
  typedef struct packed {
    logic              first_entry;
    logic              last_entry;
    logic              mixed;
    logic              entry_ok;
    logic [DATA_W-1:0] payload_offset;
    logic [DATA_W-1:0] payload_bytes;
  } rec_t;

endpackage

### rtl/piv_fifo.sv
// Small flop-based first-in first-out queue.
module piv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

### rtl/piv_front.sv
// Front part: classifies an incoming index entry against its static rules.
module piv_front (
  input  piv_pkg::cfg_t   cfg,
  input  piv_pkg::entry_t entry,
  output piv_pkg::rec_t   rec
);
  import piv_pkg::*;

  logic [15:0] cells;
  logic [16:0] bits_rounded;
  logic [13:0] expect_bytes;
  logic        is_missing;
  logic        is_mixed;
  logic        lon_in_range;
  logic        lat_in_range;
  logic        counts_ok;
  logic        payload_ok;

  assign cells        = 16'(entry.lon_samples) * 16'(entry.lat_samples);
  assign bits_rounded = 17'(cells) + 17'(BYTE_ROUND_UP);
  assign expect_bytes = bits_rounded[16:3];

  assign is_missing = (entry.coverage_code == cfg.missing_code);
  assign is_mixed   = (entry.coverage_code == cfg.mixed_code);

  assign lon_in_range = (entry.lon_samples >= MIN_SAMPLES) &&
                        (entry.lon_samples <= MAX_SAMPLES);
  assign lat_in_range = (entry.lat_samples >= MIN_SAMPLES) &&
                        (entry.lat_samples <= MAX_SAMPLES);

  // Missing cells carry no samples; every other cell needs both in range
  assign counts_ok = is_missing ? (entry.lon_samples == '0 && entry.lat_samples == '0)
                                : (lon_in_range && lat_in_range);

  assign payload_ok = is_mixed ? (entry.payload_bytes == DATA_W'(expect_bytes))
                               : (entry.payload_offset == '0 &&
                                  entry.payload_bytes == '0 &&
                                  entry.payload_checksum == '0);

  always_comb begin
    rec.first_entry    = entry.first_entry;
    rec.last_entry     = entry.last_entry;
    rec.mixed          = is_mixed;
    rec.entry_ok       = (entry.coverage_code <= cfg.mixed_code) &&
                         (entry.reserved_byte == '0) && counts_ok && payload_ok;
    rec.payload_offset = entry.payload_offset;
    rec.payload_bytes  = entry.payload_bytes;
  end

endmodule

### rtl/piv_back.sv
// Back part: applies the running offset, failure and index state to each entry.
module piv_back #(
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  piv_pkg::cfg_t    cfg,
  input  logic             rec_valid,
  input  piv_pkg::rec_t    rec,
  output logic             rec_pop,
  input  logic             res_full,
  output logic             res_push,
  output piv_pkg::result_t res
);
  import piv_pkg::*;

  localparam int unsigned CNT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [DATA_W-1:0] running_offset;
  logic              failed;
  logic [CNT_W-1:0]  counter;

  logic [DATA_W-1:0] base_off;
  logic              base_failed;
  logic [CNT_W-1:0]  idx;
  logic [DATA_W:0]   end_sum;
  logic              fits;
  logic              ok;
  logic [DATA_W-1:0] new_off;
  logic              mismatch;
  logic [DATA_W-1:0] running_offset_next;
  logic              failed_next;
  logic [CNT_W-1:0]  counter_next;
  status_t           status;

  assign rec_pop  = rec_valid && !res_full;
  assign res_push = rec_pop;

  always_comb begin
    base_off    = rec.first_entry ? cfg.first_payload_offset : running_offset;
    base_failed = rec.first_entry ? 1'b0 : failed;
    idx         = rec.first_entry ? '0 : counter;

    end_sum  = {1'b0, base_off} + {1'b0, rec.payload_bytes};
    fits     = (end_sum <= (DATA_W + 1)'(cfg.declared_file_size));
    ok       = rec.entry_ok &&
               (!rec.mixed || (rec.payload_offset == base_off && fits));
    new_off  = rec.mixed ? end_sum[DATA_W-1:0] : base_off;
    mismatch = rec.last_entry && (new_off != DATA_W'(cfg.declared_file_size));

    if (base_failed) begin
      status = ST_SKIPPED;
    end else if (!ok) begin
      status = ST_MALFORMED;
    end else if (mismatch) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_ACCEPTED;
    end

    // Hold the offset on a skipped or malformed entry
    running_offset_next = (base_failed || !ok) ? base_off : new_off;
    failed_next         = base_failed || !ok || mismatch;
    counter_next        = (idx == CNT_W'(MAX_ENTRIES - 1)) ? '0 : idx + 1'b1;

    res.status             = status;
    res.entry_index        = ENTRY_W'(idx);
    res.running_offset_out = running_offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_offset <= FIRST_OFFSET_RESET;
      failed         <= 1'b0;
      counter        <= '0;
    end else if (rec_pop) begin
      running_offset <= running_offset_next;
      failed         <= failed_next;
      counter        <= counter_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_skip_only_when_failed: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == ST_SKIPPED) |-> (failed && !rec.first_entry))
    else $error("skipped result without a standing failure");

  a_error_sets_failed: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res.status == ST_MALFORMED || res.status == ST_MISMATCH)) |=> failed)
    else $error("error result did not set failure state");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !rec_pop |=> ($stable(running_offset) && $stable(failed) && $stable(counter)))
    else $error("back state moved without an entry");
`endif

endmodule

### rtl/pack_index_entry_validator.sv
// Top level of the pack index entry validator.
//
// Validates a stream of decoded pack index entries and returns one result item
// per entry: accepted, malformed, coverage mismatch on the last entry, or
// skipped after an earlier error until an entry marked first restarts the
// check. Both sides behave as queues: push an entry while full is low, pop a
// result while empty is low. Throughput is one item per clock cycle while
// neither queue is full; an item is classified (sample counts, byte count
// against ceil(lon*lat/8), reserved byte, code range) on the cycle it is
// pushed and lands in a two-entry classification queue. The back part then
// checks it against the running payload offset and file size, updates its
// state and writes the result into a two-entry result queue, from which it
// is on the result ports and can be popped. The single-step update of the
// running offset in the back part sets the rate: one entry per cycle while
// the result queue has room. Configuration writes take effect at once; write
// only while no entry is in flight. A new first payload offset is used from
// the next restart on.
module pack_index_entry_validator #(
  parameter int unsigned MAX_ENTRIES = 65536
) (
  input  logic                               clk,
  input  logic                               rst,
  // Entry side
  input  logic                               push,
  input  piv_pkg::entry_t                    entry,
  output logic                               full,
  // Result side
  input  logic                               pop,
  output piv_pkg::result_t                   result,
  output logic                               empty,
  // Configuration writes
  input  logic                               cfg_we,
  input  logic [piv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [piv_pkg::DATA_W-1:0]         cfg_data
);
  import piv_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 2;

  cfg_t    cfg;
  rec_t    front_rec;
  rec_t    head_rec;
  logic    rec_empty;
  logic    rec_pop;
  logic    res_full;
  logic    res_push;
  result_t back_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_payload_offset <= FIRST_OFFSET_RESET;
      cfg.declared_file_size   <= FILE_SIZE_RESET;
      cfg.missing_code         <= MISSING_CODE_RESET;
      cfg.mixed_code           <= MIXED_CODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_OFFSET: cfg.first_payload_offset <= cfg_data;
        REG_FILE_SIZE:    cfg.declared_file_size   <= cfg_data[SIZE_W-1:0];
        REG_MISSING_CODE: cfg.missing_code         <= cfg_data[CODE_W-1:0];
        REG_MIXED_CODE:   cfg.mixed_code           <= cfg_data[CODE_W-1:0];
        default:          cfg.mixed_code           <= cfg.mixed_code;
      endcase
    end
  end

  // Classify the entry as it arrives
  piv_front u_front (
    .cfg   (cfg),
    .entry (entry),
    .rec   (front_rec)
  );

  // Decouple classification from the stateful check
  piv_fifo #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_rec_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_rec),
    .full  (full),
    .pop   (rec_pop),
    .rdata (head_rec),
    .empty (rec_empty)
  );

  // Apply running offset, failure and index state
  piv_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (!rec_empty),
    .rec       (head_rec),
    .rec_pop   (rec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  // Hold finished results until the consumer pops them
  piv_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`ifndef NO_ASSERTIONS
  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  a_drain_needs_entry: assert property (@(posedge clk) disable iff (rst)
    rec_pop |-> !rec_empty)
    else $error("back part took an entry from an empty queue");

  a_result_follows_entry: assert property (@(posedge clk) disable iff (rst)
    (rec_empty && !$past(rec_pop) && empty && !push) |=> rec_empty)
    else $error("entry appeared in the queue without a push");
`endif

endmodule

### test/piv_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the pack index entry validator: predicts each verdict and compares.
module piv_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  piv_pkg::entry_t               entry,
  input  logic                          pop,
  input  logic                          empty,
  input  piv_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [piv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [piv_pkg::DATA_W-1:0]    cfg_data,
  output int unsigned                   errors,
  output int unsigned                   pending
);
  import piv_pkg::*;

  // Register copies
  logic [DATA_W-1:0]  first_offset;
  logic [SIZE_W-1:0]  file_size;
  logic [CODE_W-1:0]  missing_code;
  logic [CODE_W-1:0]  mixed_code;

  // Validation state
  logic [DATA_W-1:0]  run_offset;
  logic               failed;
  logic [ENTRY_W-1:0] entry_count;

  result_t            pending_verdicts[$];
  int unsigned        mismatches = 0;

  function automatic logic counts_legal(input logic [7:0] code, input logic [7:0] lon,
                                        input logic [7:0] lat);
    if (code == missing_code) return (lon == 8'd0) && (lat == 8'd0);
    return (lon >= MIN_SAMPLES) && (lon <= MAX_SAMPLES) &&
           (lat >= MIN_SAMPLES) && (lat <= MAX_SAMPLES);
  endfunction

  // Verdict for one entry; advances the validation state.
  function automatic result_t judge_entry(input entry_t e);
    result_t           r;
    logic              is_mixed;
    logic              good;
    logic [DATA_W-1:0] need_bytes;
    logic [DATA_W:0]   payload_end;
    if (e.first_entry) begin
      run_offset  = first_offset;
      failed      = 1'b0;
      entry_count = '0;
    end
    r.entry_index = entry_count;
    if (failed) begin
      r.status = ST_SKIPPED;
    end else begin
      is_mixed = (e.coverage_code == mixed_code);
      good = (e.coverage_code <= mixed_code) && (e.reserved_byte == 8'd0) &&
             counts_legal(e.coverage_code, e.lon_samples, e.lat_samples);
      if (is_mixed) begin
        need_bytes  = (32'(e.lon_samples) * 32'(e.lat_samples) + 32'(BYTE_ROUND_UP)) / 32'd8;
        payload_end = {1'b0, run_offset} + {1'b0, e.payload_bytes};
        good = good && (e.payload_bytes == need_bytes) && (e.payload_offset == run_offset) &&
               (payload_end <= 33'(file_size));
      end else begin
        good = good && (e.payload_offset == '0) && (e.payload_bytes == '0) &&
               (e.payload_checksum == '0);
      end
      if (!good) begin
        r.status = ST_MALFORMED;
        failed   = 1'b1;
      end else begin
        if (is_mixed) run_offset = run_offset + e.payload_bytes;
        if (e.last_entry && (run_offset != 32'(file_size))) begin
          r.status = ST_MISMATCH;
          failed   = 1'b1;
        end else begin
          r.status = ST_ACCEPTED;
        end
      end
    end
    // 16-bit counter wraps at 65536, the default MAX_ENTRIES
    entry_count = entry_count + 1'b1;
    r.running_offset_out = run_offset;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      first_offset = FIRST_OFFSET_RESET;
      file_size    = FILE_SIZE_RESET;
      missing_code = MISSING_CODE_RESET;
      mixed_code   = MIXED_CODE_RESET;
      run_offset   = FIRST_OFFSET_RESET;
      failed       = 1'b0;
      entry_count  = '0;
      pending_verdicts.delete();
    end else begin
      if (pop && !empty) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result item: expected no item, ", $time,
                   "got status %0d index %0d offset %0d",
                   result.status, result.entry_index, result.running_offset_out);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (result.status !== want.status || result.entry_index !== want.entry_index ||
              result.running_offset_out !== want.running_offset_out) begin
            $display("%0t: result mismatch: expected status %0d index %0d offset %0d, ",
                     $time, want.status, want.entry_index, want.running_offset_out,
                     "got status %0d index %0d offset %0d",
                     result.status, result.entry_index, result.running_offset_out);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_OFFSET: first_offset = cfg_data;
          REG_FILE_SIZE:    file_size    = cfg_data[SIZE_W-1:0];
          REG_MISSING_CODE: missing_code = cfg_data[CODE_W-1:0];
          REG_MIXED_CODE:   mixed_code   = cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) pending_verdicts = {pending_verdicts, judge_entry(entry)};
    end
    pending <= pending_verdicts.size();
    errors  <= mismatches;
  end

endmodule

### test/pack_index_entry_validator_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives index entry items and register writes into the validator.
module pack_index_entry_validator_tb;
  import piv_pkg::*;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned PHASE_ITEMS     = 190;
  // No correct run goes this long without a handshake, not even across reset,
  // register writes and the settle pause.
  localparam int unsigned STALL_LIMIT     = 2000;
  // A result pops only after it has passed both queues; leave some slack
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned SPAN_LIMIT      = 4000;
  localparam int unsigned FULL_CELL_BYTES = 1831;   // 121 x 121 samples, rounded up
  localparam logic [SIZE_W-1:0] SIZE_MAX  = 28'd134217728;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  entry_t               entry = '0;
  logic                 full;
  logic                 pop = 1'b0;
  result_t              result;
  logic                 empty;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  int unsigned          errors;
  int unsigned          pending;

  // Idle percentages of the two sides, changed per phase
  int unsigned          send_idle_pct = 15;
  int unsigned          recv_idle_pct = 59;

  // Register values as last written; used to shape well-formed entry files
  logic [DATA_W-1:0]    cur_first   = FIRST_OFFSET_RESET;
  logic [SIZE_W-1:0]    cur_size    = FILE_SIZE_RESET;
  logic [CODE_W-1:0]    cur_missing = MISSING_CODE_RESET;
  logic [CODE_W-1:0]    cur_mixed   = MIXED_CODE_RESET;

  pack_index_entry_validator i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry     (entry),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  piv_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .entry     (entry),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  // Result side: take results at random, held low during reset
  initial begin : result_drain
    forever begin
      @(negedge clk);
      pop <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // End the run when no handshake happens for too long
  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic entry_t make_cell(input logic first, input logic last,
                                       input logic [7:0] code, input logic [7:0] lon,
                                       input logic [7:0] lat, input logic [7:0] rsv,
                                       input logic [DATA_W-1:0] poff,
                                       input logic [DATA_W-1:0] pbytes,
                                       input logic [DATA_W-1:0] crc);
    entry_t e;
    e.first_entry      = first;
    e.last_entry       = last;
    e.coverage_code    = code;
    e.lon_samples      = lon;
    e.lat_samples      = lat;
    e.reserved_byte    = rsv;
    e.payload_offset   = poff;
    e.payload_bytes    = pbytes;
    e.payload_checksum = crc;
    return e;
  endfunction

  // Every field fully random: reaches all bits and the odd corners
  function automatic entry_t noise_entry();
    return make_cell(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
  endfunction

  function automatic logic [7:0] legal_samples();
    return 8'($urandom_range(MIN_SAMPLES, MAX_SAMPLES));
  endfunction

  // Find sample counts whose packed bit payload is exactly want bytes
  function automatic bit exact_cell(input int unsigned want, output logic [7:0] lon,
                                    output logic [7:0] lat);
    int unsigned start;
    int unsigned k;
    int unsigned a;
    int unsigned b;
    start = $urandom_range(0, 119);
    lon = '0;
    lat = '0;
    for (k = 0; k < 120; k++) begin
      a = MIN_SAMPLES + (start + k) % 120;
      b = (8 * want - 7 + a - 1) / a;
      if (b < MIN_SAMPLES) b = MIN_SAMPLES;
      if (b <= MAX_SAMPLES && a * b <= 8 * want) begin
        lon = 8'(a);
        lat = 8'(b);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Present one item after a random gap; return once it is taken.
  // Push stays high into the next item unless a gap follows.
  task automatic drive_entry(input entry_t e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push  <= 1'b1;
    entry <= e;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push and wait until every result has come back
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; only called while idle
  task automatic apply_config(input logic [DATA_W-1:0] first_off, input logic [SIZE_W-1:0] size,
                              input logic [CODE_W-1:0] miss, input logic [CODE_W-1:0] mix);
    cur_first   = first_off;
    cur_size    = size;
    cur_missing = miss;
    cur_mixed   = mix;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIRST_OFFSET;
    cfg_data  <= first_off;
    @(negedge clk);
    cfg_index <= REG_FILE_SIZE;
    cfg_data  <= 32'(size);
    @(negedge clk);
    cfg_index <= REG_MISSING_CODE;
    cfg_data  <= 32'(miss);
    @(negedge clk);
    cfg_index <= REG_MIXED_CODE;
    cfg_data  <= 32'(mix);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Register settings per phase: extremes first, fully random last
  task automatic pick_config(input int unsigned phase);
    int unsigned       span;
    logic [DATA_W-1:0] first_off;
    span = $urandom_range(1, SPAN_LIMIT);
    case (phase)
      0: apply_config('0, SIZE_W'(span), 8'd0, 8'd2);
      1: begin
        first_off = $urandom_range(0, 1 << 20);
        apply_config(first_off, SIZE_W'(first_off + span), 8'd1, 8'd3);
      end
      // missing and mixed share one code
      2: apply_config(32'd64, SIZE_W'(64 + span), 8'd5, 8'd5);
      3: apply_config(32'd8, SIZE_W'(8 + span), 8'd0, 8'hFF);
      // missing code above mixed code: only mixed cells can pass
      4: apply_config('0, SIZE_W'(span), 8'hFF, 8'd0);
      // start beyond the file: every mixed payload overruns
      5: apply_config('1, SIZE_MAX, 8'd0, 8'd2);
      6: apply_config(32'(SIZE_MAX) - span, SIZE_MAX, 8'd7, 8'd200);
      default: begin
        first_off = $urandom_range(0, 32'(SIZE_MAX) - SPAN_LIMIT - 1);
        apply_config(first_off, SIZE_W'(first_off + span), 8'($urandom), 8'($urandom));
      end
    endcase
  endtask

  // One file of index entries: restart, cells with random content whose
  // payloads follow one another, mostly closing exactly at the file size.
  // About a quarter of the files carry one broken entry.
  task automatic send_file(output int unsigned n_cells);
    int unsigned       remaining;
    int unsigned       bad_at;
    int unsigned       k;
    int unsigned       kind;
    int unsigned       tries;
    int unsigned       nbytes;
    logic [DATA_W-1:0] offset;
    logic [7:0]        lon;
    logic [7:0]        lat;
    entry_t            e;
    n_cells   = $urandom_range(1, 12);
    bad_at    = ($urandom_range(0, 99) < 25) ? $urandom_range(0, n_cells - 1) : n_cells;
    offset    = cur_first;
    remaining = ({4'b0, cur_size} > cur_first) ? {4'b0, cur_size} - cur_first : 0;
    for (k = 0; k < n_cells; k++) begin
      e = '0;
      e.first_entry = (k == 0);
      // now and then the file ends without a last mark
      e.last_entry  = (k == n_cells - 1) && ($urandom_range(0, 9) != 0);
      kind = $urandom_range(0, 2);        // 0 missing, 1 other, 2 mixed
      if (k == n_cells - 1 && remaining != 0) kind = 2;
      if (cur_missing > cur_mixed) kind = 2;
      // mixed with no room left overruns: keep it rare
      if (kind == 2 && remaining == 0 && $urandom_range(0, 9) != 0) kind = 0;
      if (kind == 1) begin
        e.coverage_code = cur_mixed;
        for (tries = 0; tries < 8 && (e.coverage_code == cur_mixed ||
             e.coverage_code == cur_missing); tries++)
          e.coverage_code = 8'($urandom_range(0, cur_mixed));
        if (e.coverage_code == cur_mixed || e.coverage_code == cur_missing) begin
          kind = 0;
        end else begin
          e.lon_samples = legal_samples();
          e.lat_samples = legal_samples();
        end
      end
      if (kind == 0) e.coverage_code = cur_missing;
      if (kind == 2) begin
        e.coverage_code = cur_mixed;
        // a shared missing/mixed code needs zero counts
        if (cur_missing != cur_mixed) begin
          lon = legal_samples();
          lat = legal_samples();
          nbytes = (32'(lon) * 32'(lat) + 7) / 8;
          if ((nbytes > remaining || k == n_cells - 1) && remaining != 0 &&
              remaining <= FULL_CELL_BYTES)
            void'(exact_cell(remaining, lon, lat));
          e.lon_samples = lon;
          e.lat_samples = lat;
        end
        e.payload_checksum = $urandom;
      end
      if (e.coverage_code == cur_mixed) begin
        nbytes = (32'(e.lon_samples) * 32'(e.lat_samples) + 7) / 8;
        e.payload_offset = offset;
        e.payload_bytes  = nbytes;
        offset    = offset + nbytes;
        remaining = (nbytes >= remaining) ? 0 : remaining - nbytes;
      end
      if (k == bad_at) begin
        case ($urandom_range(0, 5))
          0: e.reserved_byte = 8'($urandom_range(1, 255));
          1: e.lon_samples = 8'($urandom);
          2: e.payload_offset = e.payload_offset ^ (32'd1 << $urandom_range(0, 31));
          3: e.payload_bytes = e.payload_bytes + 1;
          4: e.payload_checksum = $urandom | 32'd1;
          default: e.coverage_code = 8'($urandom_range(cur_mixed, 255));
        endcase
      end
      drive_entry(e);
    end
  endtask

  // Hand-picked entries: each rule and special case once
  task automatic directed_entries();
    logic [7:0] other;
    // Reset settings: the running offset already holds the reset start
    drive_entry(make_cell(1'b0, 1'b0, cur_missing, 8'd0, 8'd0, 8'd0, '0, '0, '0));
    // file size zero: the smallest payload already overruns
    drive_entry(make_cell(1'b0, 1'b0, cur_mixed, 8'd2, 8'd2, 8'd0, FIRST_OFFSET_RESET,
                          32'd1, '0));
    drive_entry(make_cell(1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1, '1, '1));
    settle();
    // Payloads 1831 + 1 + 2 starting at 16 fill the file exactly
    apply_config(32'd16, 28'd1850, 8'd0, 8'd2);
    other = cur_mixed - 8'd1;
    drive_entry(make_cell(1'b1, 1'b0, cur_mixed, 8'd121, 8'd121, 8'd0, 32'd16, 32'd1831, '1));
    drive_entry(make_cell(1'b0, 1'b0, other, 8'd2, 8'd121, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b0, 1'b0, cur_missing, 8'd0, 8'd0, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b0, 1'b0, cur_mixed, 8'd2, 8'd2, 8'd0, 32'd1847, 32'd1, '0));
    drive_entry(make_cell(1'b0, 1'b1, cur_mixed, 8'd3, 8'd3, 8'd0, 32'd1848, 32'd2, '0));
    // entries after a last entry just go on
    drive_entry(make_cell(1'b0, 1'b0, cur_missing, 8'd0, 8'd0, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b0, 1'b1, cur_missing, 8'd0, 8'd0, 8'd0, '0, '0, '0));
    // restart on a last entry that falls short of the file size, then skip
    drive_entry(make_cell(1'b1, 1'b1, cur_missing, 8'd0, 8'd0, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b0, 1'b0, cur_missing, 8'd0, 8'd0, 8'd0, '0, '0, '0));
    // one broken rule per restart
    drive_entry(make_cell(1'b1, 1'b0, cur_mixed + 8'd1, 8'd2, 8'd2, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b1, 1'b0, cur_missing, 8'd0, 8'd0, 8'd1, '0, '0, '0));
    drive_entry(make_cell(1'b1, 1'b0, cur_missing, 8'd1, 8'd0, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b1, 1'b0, other, 8'd1, 8'd2, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b1, 1'b0, other, 8'd122, 8'd121, 8'd0, '0, '0, '0));
    drive_entry(make_cell(1'b1, 1'b0, other, 8'd2, 8'd2, 8'd0, '0, '0, 32'd1));
    drive_entry(make_cell(1'b1, 1'b0, other, 8'd2, 8'd2, 8'd0, 32'd4, '0, '0));
    drive_entry(make_cell(1'b1, 1'b0, cur_mixed, 8'd2, 8'd2, 8'd0, 32'd16, 32'd2, '0));
    drive_entry(make_cell(1'b1, 1'b0, cur_mixed, 8'd2, 8'd2, 8'd0, 32'd17, 32'd1, '0));
    // a malformed last entry reports malformed, not a coverage mismatch
    drive_entry(make_cell(1'b1, 1'b1, other, 8'd2, 8'd2, 8'd1, '0, '0, '0));
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned sent;
    int unsigned n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_entries();

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      pick_config(phase);
      // receiver lazy first, then sender lazy, then full speed
      if (phase < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 59;
      end else if (phase < 6) begin
        send_idle_pct = 59;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          drive_entry(noise_entry());
          sent++;
        end else begin
          send_file(n);
          sent += n;
        end
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
